[rtl/core/bitmap_page_allocator_core_defines.svh]
// Assertion macros shared by the page allocator RTL.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BPA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPA_ASSERT(label, clk, rstn, prop, msg)
`define BPA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/core/bpa_pkg.sv]
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;
  localparam int unsigned PageBytes = 4096;
  localparam int unsigned MaxPages  = 16384;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned WordCount = (MaxPages + WordBits - 1) / WordBits;
  localparam int unsigned OffW      = $clog2(PageBytes);
  localparam int unsigned BitW      = $clog2(WordBits);
  localparam int unsigned WIdxW     = $clog2(WordCount);
  localparam int unsigned CntW      = 15;
  localparam int unsigned PageW     = 33 - OffW;
  localparam logic [31:0] ResetBase = 32'h0050_0000;
  localparam logic [CntW-1:0] ResetPages = 15'd1024;
  localparam logic [CntW-1:0] MaxPagesC = CntW'(MaxPages);

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  typedef enum logic [0:0] {
    REG_BASE  = 1'b0,
    REG_PAGES = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WAIT,
    ST_MOD,
    ST_OUT
  } state_e;

  // Lowest clear bit of a word; valid flag set when any is clear.
  typedef struct packed {
    logic            found;
    logic [BitW-1:0] pos;
  } scan_t;
endpackage

[rtl/core/bitmap_page_allocator_core.sv]
// Top level of the bitmap page allocator: control, bitmap memory and ports.
//
//  Channel   Direction  Signals
//  request   in         req_valid_i/req_ready_o: req_type_i, address_i, length_i
//  result    out        res_valid_o/res_ready_i: page_addr_o, granted_o, free_pages_o
//  config    in         APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One request word is handled at a time. The bitmap lives in a single-port RAM,
// so each bitmap word takes three steps (read, wait, modify and write back).
// An allocation walks words from the start of the window until one has a free
// bit, and a range walks every word it touches.
// After reset, and after any configuration write, a clearing pass zeroes all 512
// words, one per cycle; no request word is taken during that pass.
// The result sits in a register; a stalled result only delays the next request.
`include "bitmap_page_allocator_core_defines.svh"
module bitmap_page_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] address_i,
  input  logic [31:0] length_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [31:0] page_addr_o,
  output logic        granted_o,
  output logic [14:0] free_pages_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned OffW  = bpa_pkg::OffW;
  localparam int unsigned PageW = bpa_pkg::PageW;
  localparam int unsigned WIdxW = bpa_pkg::WIdxW;
  localparam int unsigned BitW  = bpa_pkg::BitW;
  localparam int unsigned WB    = bpa_pkg::WordBits;
  localparam int unsigned CntW  = bpa_pkg::CntW;

  bpa_pkg::state_e state_q, state_d;

  logic [31:0]     base_q;
  logic [CntW-1:0] pages_q;
  logic [CntW-1:0] free_q, free_d;
  logic [WIdxW:0]  clr_q;

  // Per-item work registers: kind, page range [first, last) and current word.
  logic [1:0]       kind_q;
  logic [PageW-1:0] first_q, last_q;
  logic [WIdxW:0]   widx_q;
  logic             hit_q;
  logic [PageW-1:0] hit_pg_q;
  logic [31:0]      pa_q;
  logic             gr_q;

  logic            cfg_wr;
  logic            ram_we;
  logic [WIdxW-1:0] ram_addr;
  logic [WB-1:0]   ram_wdata, ram_rdata;
  bpa_pkg::scan_t  scan;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      bpa_pkg::REG_BASE:  prdata = base_q;
      bpa_pkg::REG_PAGES: prdata = {17'd0, pages_q};
      default:            prdata = '0;
    endcase
  end

  // Window end in pages is just pages_q; addresses are turned into page numbers
  // relative to the base. The range end is summed at 34 bits so that it cannot
  // wrap, and an end beyond the page-number width saturates, as it is clipped.
  logic [33:0]      end_b;
  logic [PageW-1:0] base_pg, s_pg, e_pg, rel_s, rel_e, lim;
  logic             range_hit, free_ok;
  always_comb begin
    end_b   = {2'b00, address_i} + {2'b00, length_i} + 34'(bpa_pkg::PageBytes - 1);
    base_pg = PageW'(base_q >> OffW);
    s_pg    = PageW'(address_i >> OffW);
    e_pg    = end_b[33] ? '1 : end_b[32:OffW];
    lim     = PageW'(pages_q);
    rel_s   = (s_pg > base_pg) ? s_pg - base_pg : '0;
    rel_e   = (e_pg > base_pg) ? e_pg - base_pg : '0;
    if (rel_e > lim) rel_e = lim;
    range_hit = (length_i != 32'd0) && (rel_s < rel_e);
    free_ok   = (address_i[OffW-1:0] == '0) && (s_pg >= base_pg)
                && ((s_pg - base_pg) < lim);
  end

  // Page index of the first bit of the word currently being handled.
  logic [PageW-1:0] wbase;
  logic [WB-1:0]    mask;
  logic [WB-1:0]    newword;
  logic [BitW:0]    delta;
  logic [PageW-1:0] hp;
  assign wbase = PageW'(widx_q) << BitW;
  always_comb begin
    mask = '0;
    for (int i = 0; i < int'(WB); i++) begin
      if ((wbase + PageW'(i) >= first_q) && (wbase + PageW'(i) < last_q)) begin
        mask[i] = 1'b1;
      end
    end
  end

  always_comb begin
    newword = ram_rdata;
    delta   = '0;
    hp      = wbase + PageW'(scan.pos);
    case (kind_q)
      bpa_pkg::REQ_ALLOC: begin
        if (scan.found && (hp < last_q)) begin
          newword = ram_rdata | (WB'(1) << scan.pos);
          delta   = (BitW+1)'(1);
        end
      end
      bpa_pkg::REQ_RESERVE: begin
        newword = ram_rdata | mask;
        delta   = (BitW+1)'($countones(mask & ~ram_rdata));
      end
      default: begin
        newword = ram_rdata & ~mask;
        delta   = (BitW+1)'($countones(mask & ram_rdata));
      end
    endcase
  end

  bpa_scan u_scan (.word_i(ram_rdata), .scan_o(scan));

  bpa_ram #(.Width(WB), .Depth(bpa_pkg::WordCount)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic [WIdxW:0] last_w;
  assign last_w = (WIdxW+1)'((last_q - PageW'(1)) >> BitW);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpa_pkg::ST_CLEAR: if (clr_q == (WIdxW+1)'(bpa_pkg::WordCount - 1))
                           state_d = bpa_pkg::ST_IDLE;
      bpa_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          if (req_type_i == bpa_pkg::REQ_ALLOC) begin
            state_d = (pages_q != '0) ? bpa_pkg::ST_RD : bpa_pkg::ST_OUT;
          end else if (req_type_i == bpa_pkg::REQ_FREE) begin
            state_d = free_ok ? bpa_pkg::ST_RD : bpa_pkg::ST_OUT;
          end else begin
            state_d = range_hit ? bpa_pkg::ST_RD : bpa_pkg::ST_OUT;
          end
        end
      end
      bpa_pkg::ST_RD:   state_d = bpa_pkg::ST_WAIT;
      bpa_pkg::ST_WAIT: state_d = bpa_pkg::ST_MOD;
      bpa_pkg::ST_MOD: begin
        if ((kind_q == bpa_pkg::REQ_ALLOC && scan.found) || widx_q >= last_w)
          state_d = bpa_pkg::ST_OUT;
        else
          state_d = bpa_pkg::ST_RD;
      end
      bpa_pkg::ST_OUT:  if (res_ready_i) state_d = bpa_pkg::ST_IDLE;
      default:          state_d = bpa_pkg::ST_CLEAR;
    endcase
    if (cfg_wr) state_d = bpa_pkg::ST_CLEAR;
  end

  // Outputs and datapath controls.
  always_comb begin
    req_ready_o = (state_q == bpa_pkg::ST_IDLE) && !cfg_wr;
    res_valid_o = (state_q == bpa_pkg::ST_OUT);
    ram_we      = 1'b0;
    ram_addr    = widx_q[WIdxW-1:0];
    ram_wdata   = newword;
    free_d      = free_q;
    case (state_q)
      bpa_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q[WIdxW-1:0];
        ram_wdata = '0;
      end
      bpa_pkg::ST_MOD: begin
        ram_we = 1'b1;
        if (kind_q == bpa_pkg::REQ_RELEASE || kind_q == bpa_pkg::REQ_FREE)
          free_d = free_q + CntW'(delta);
        else if (CntW'(delta) > free_q)
          free_d = '0;
        else
          free_d = free_q - CntW'(delta);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::ST_CLEAR;
      clr_q   <= '0;
      base_q  <= bpa_pkg::ResetBase;
      pages_q <= bpa_pkg::ResetPages;
      free_q  <= bpa_pkg::ResetPages;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      if (state_q == bpa_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_wr) begin
        clr_q <= '0;
        case (paddr[2])
          bpa_pkg::REG_BASE: begin
            base_q <= {pwdata[31:OffW], OffW'(0)};
            free_q <= pages_q;
          end
          bpa_pkg::REG_PAGES: begin
            pages_q <= (pwdata[CntW-1:0] > bpa_pkg::MaxPagesC) ? bpa_pkg::MaxPagesC
                                                               : pwdata[CntW-1:0];
            free_q  <= (pwdata[CntW-1:0] > bpa_pkg::MaxPagesC) ? bpa_pkg::MaxPagesC
                                                               : pwdata[CntW-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // Work registers need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == bpa_pkg::ST_IDLE && req_valid_i) begin
      kind_q <= req_type_i;
      gr_q   <= 1'b1;
      pa_q   <= '0;
      hit_q  <= 1'b0;
      case (req_type_i)
        bpa_pkg::REQ_ALLOC: begin
          first_q <= '0;
          last_q  <= PageW'(pages_q);
          widx_q  <= '0;
          gr_q    <= 1'b0;
        end
        bpa_pkg::REQ_FREE: begin
          first_q <= s_pg - base_pg;
          last_q  <= s_pg - base_pg + PageW'(1);
          widx_q  <= (WIdxW+1)'((s_pg - base_pg) >> BitW);
        end
        default: begin
          first_q <= rel_s;
          last_q  <= rel_e;
          widx_q  <= (WIdxW+1)'(rel_s >> BitW);
        end
      endcase
    end else if (state_q == bpa_pkg::ST_MOD) begin
      widx_q <= widx_q + 1'b1;
      if (kind_q == bpa_pkg::REQ_ALLOC && scan.found && hp < last_q) begin
        hit_q    <= 1'b1;
        hit_pg_q <= hp;
        gr_q     <= 1'b1;
        pa_q     <= base_q + (32'(hp) << OffW);
      end
    end
  end

  assign page_addr_o  = pa_q;
  assign granted_o    = gr_q;
  assign free_pages_o = free_q;

  `BPA_ASSERT(a_free_bound, clk_i, rst_ni, free_q <= pages_q, "free count above page count")
  `BPA_ASSERT(a_no_ready_busy, clk_i, rst_ni, res_valid_o |-> !req_ready_o, "ready while result held")
  `BPA_ASSERT(a_hit_grant, clk_i, rst_ni, (res_valid_o && kind_q == bpa_pkg::REQ_ALLOC) |-> (gr_q == hit_q), "grant mismatch")
  `BPA_ASSERT(a_hit_in_window, clk_i, rst_ni, (res_valid_o && hit_q && kind_q == bpa_pkg::REQ_ALLOC) |-> (hit_pg_q < PageW'(pages_q)), "page outside window")
endmodule

[rtl/core/bpa_ram.sv]
// Generic single-port RAM with registered read.
module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/core/bpa_scan.sv]
// Finds the lowest clear bit of a bitmap word.
module bpa_scan (
  input  logic [bpa_pkg::WordBits-1:0] word_i,
  output bpa_pkg::scan_t               scan_o
);
  logic [bpa_pkg::WordBits-1:0] inv;
  logic [bpa_pkg::WordBits-1:0] low;

  // Isolate the lowest set bit of the inverted word, then encode it.
  always_comb begin
    inv = ~word_i;
    low = inv & (~inv + bpa_pkg::WordBits'(1));
    scan_o.found = |inv;
    scan_o.pos   = '0;
    for (int i = 0; i < int'(bpa_pkg::WordBits); i++) begin
      if (low[i]) begin
        scan_o.pos = bpa_pkg::BitW'(i);
      end
    end
  end
endmodule
